/* sv/ctns_pkg.sv */
// package: constants, types and sine table for the click synthesizer
`default_nettype none
package ctns_pkg;

    localparam int SINE_TABLE_BITS = 8;
    localparam int CFG_COUNT       = 7;
    localparam int CFG_IDX_W       = 3;
    localparam int MUL_W           = 32;
    localparam int MUL_CNT_W       = 6;

    localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCENT_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCENT_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_DECAY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_DECAY = 3'd6;

    localparam logic [31:0] NOISE_SEED  = 32'hDEADBEEF;
    localparam logic [31:0] LCG_MUL     = 32'd1664525;
    localparam logic [31:0] LCG_ADD     = 32'd1013904223;
    localparam logic [15:0] SHAPE_OFS   = 16'd3129;
    localparam logic [15:0] TONE_LEVEL  = 16'd13107;
    localparam logic [15:0] NOISE_LEVEL = 16'd19661;
    localparam logic [15:0] ENV_FULL    = 16'hFFFF;

    typedef struct packed {
        logic [15:0] duration_samples;
        logic [14:0] normal_phase_step;
        logic [14:0] accent_phase_step;
        logic [15:0] normal_gain;
        logic [15:0] accent_gain;
        logic [15:0] tone_decay_factor;
        logic [15:0] noise_decay_factor;
    } cfg_t;

    // multiplier request / response between sequencer and serial multiplier
    typedef struct packed {
        logic              start;
        logic [MUL_W-1:0]  a;
        logic [MUL_W-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic                busy;
        logic [2*MUL_W-1:0]  prod;
    } mul_rsp_t;

    function automatic logic [15:0] quarter_sine(input logic [15:0] z);
        logic [31:0] z2;
        logic [31:0] t;
        logic [31:0] r;
        z2 = ({16'd0, z} * {16'd0, z}) >> 15;
        t  = 32'd21167 - ((z2 * 32'd2611) >> 15);
        t  = 32'd51472 - ((z2 * t) >> 15);
        r  = ({16'd0, z} * t) >> 15;
        if (r > 32'd32767) r = 32'd32767;
        return r[15:0];
    endfunction

    // one sine table entry for an angle code, evaluated at elaboration
    function automatic logic [15:0] sine_entry(input logic [SINE_TABLE_BITS-1:0] idx);
        logic [15:0] a;
        logic [15:0] z;
        logic [15:0] v;
        a = {idx, {(16-SINE_TABLE_BITS){1'b0}}};
        z = {1'b0, a[13:0], 1'b0};
        v = a[14] ? quarter_sine(16'd32768 - z) : quarter_sine(z);
        return a[15] ? -$signed(v) : $signed(v);
    endfunction

    typedef logic [(1<<SINE_TABLE_BITS)-1:0][15:0] sine_tab_t;

    function automatic sine_tab_t make_sine_tab();
        sine_tab_t tab;
        for (int i = 0; i < (1<<SINE_TABLE_BITS); i++)
            tab[i] = sine_entry(SINE_TABLE_BITS'(i));
        return tab;
    endfunction

    // constant sine table, indexed by the top angle bits
    localparam sine_tab_t SINE_TAB = make_sine_tab();

    function automatic logic signed [15:0] sine_rom(input logic [SINE_TABLE_BITS-1:0] idx);
        return $signed(SINE_TAB[idx]);
    endfunction

endpackage
`default_nettype wire

/* sv/ctns_if.sv */
// handshake channel interfaces for the click synthesizer
`default_nettype none
interface ctns_in_if;
    logic valid;
    logic ready;
    logic trigger;
    logic accented;
    modport source (output valid, trigger, accented, input ready);
    modport sink   (input valid, trigger, accented, output ready);
endinterface

interface ctns_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] click_sample;
    logic               click_running;
    modport source (output valid, click_sample, click_running, input ready);
    modport sink   (input valid, click_sample, click_running, output ready);
endinterface

interface ctns_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/ctns_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module ctns_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctns_pkg::mul_req_t req,
    output ctns_pkg::mul_rsp_t     rsp
);
    logic [2*ctns_pkg::MUL_W-1:0] acc_reg, acc_next;
    logic [2*ctns_pkg::MUL_W-1:0] mcand_reg, mcand_next;
    logic [ctns_pkg::MUL_W-1:0]   mplier_reg, mplier_next;
    logic [ctns_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;

    // one partial product per cycle
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        if (req.start)
        begin
            acc_next    = '0;
            mcand_next  = {{ctns_pkg::MUL_W{1'b0}}, req.a};
            mplier_next = req.b;
            cnt_next    = ctns_pkg::MUL_CNT_W'(ctns_pkg::MUL_W);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == ctns_pkg::MUL_CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.prod = acc_reg;

    ap_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0) else $error("busy with zero count");
    ap_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == ctns_pkg::MUL_CNT_W'(1) && !req.start) |=> !busy_reg)
        else $error("multiplier overran");
    ap_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("start lost");
endmodule
`default_nettype wire

/* sv/ctns_regs.sv */
// configuration register file
`default_nettype none
module ctns_regs (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ctns_cfg_if.sink    cfg,
    output ctns_pkg::cfg_t regs
);
    ctns_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;

    // register writes by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.duration_samples   <= 16'd1440;
            regs_reg.normal_phase_step  <= 15'd1365;
            regs_reg.accent_phase_step  <= 15'd2048;
            regs_reg.normal_gain        <= 16'd16384;
            regs_reg.accent_gain        <= 16'd16384;
            regs_reg.tone_decay_factor  <= 16'd64722;
            regs_reg.noise_decay_factor <= 16'd64992;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ctns_pkg::REG_DURATION:    regs_reg.duration_samples   <= cfg.data;
                ctns_pkg::REG_NORMAL_STEP: regs_reg.normal_phase_step  <= cfg.data[14:0];
                ctns_pkg::REG_ACCENT_STEP: regs_reg.accent_phase_step  <= cfg.data[14:0];
                ctns_pkg::REG_NORMAL_GAIN: regs_reg.normal_gain        <= cfg.data;
                ctns_pkg::REG_ACCENT_GAIN: regs_reg.accent_gain        <= cfg.data;
                ctns_pkg::REG_TONE_DECAY:  regs_reg.tone_decay_factor  <= cfg.data;
                ctns_pkg::REG_NOISE_DECAY: regs_reg.noise_decay_factor <= cfg.data;
                default: ;
            endcase
        end
    end

    assign regs = regs_reg;
endmodule
`default_nettype wire

/* sv/ctns_core.sv */
// sample sequencer: runs the per-sample products through the serial multiplier
`default_nettype none
module ctns_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  ctns_pkg::cfg_t regs,
    ctns_in_if.sink        in_ch,
    ctns_out_if.source     out_ch
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_START = 8'b00000010,
        S_MUL   = 8'b00000100,
        S_WAIT  = 8'b00001000,
        S_NEXT  = 8'b00010000,
        S_DONE  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_HOLD  = 8'b10000000
    } state_t;

    // product steps of one sample
    typedef enum logic [3:0] {
        P_LCG, P_TONE1, P_TONE2, P_SHAPE, P_NZ1, P_NZ2, P_GAIN, P_TENV, P_NENV, P_LAST
    } step_t;

    state_t state_reg, state_next;
    step_t  step_reg;
    logic        active_reg;
    logic [15:0] remain_reg;
    logic        accent_reg;
    logic [15:0] phase_reg;
    logic [31:0] noise_reg;
    logic [15:0] tenv_reg;
    logic [15:0] nenv_reg;
    logic signed [31:0] tone_reg, nz_reg, sample_reg;
    logic signed [15:0] res_sample_reg;
    logic        res_run_reg;
    logic        out_valid_reg;

    ctns_pkg::mul_req_t req;
    ctns_pkg::mul_rsp_t rsp;
    logic neg_reg;

    ctns_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    // signed magnitude helpers
    function automatic logic [31:0] mag(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    logic [15:0] shape_ang;
    logic signed [15:0] sin_tone, sin_shape;
    logic [16:0] phase3;
    logic [15:0] step_sel;
    logic [15:0] gain_sel;
    logic signed [31:0] noise_val;
    logic [63:0] prod;
    logic signed [31:0] sres;

    always_comb
    begin
        phase3    = ({1'b0, phase_reg} + {phase_reg, 1'b0}) >> 1;
        shape_ang = phase3[15:0] + ctns_pkg::SHAPE_OFS;
        sin_tone  = ctns_pkg::sine_rom(phase_reg[15 -: ctns_pkg::SINE_TABLE_BITS]);
        sin_shape = ctns_pkg::sine_rom(shape_ang[15 -: ctns_pkg::SINE_TABLE_BITS]);
        step_sel  = accent_reg ? {1'b0, regs.accent_phase_step}
                               : {1'b0, regs.normal_phase_step};
        gain_sel  = accent_reg ? regs.accent_gain : regs.normal_gain;
        noise_val = $signed({16'd0, noise_reg[31:16]}) - 32'sd32768;
        prod      = rsp.prod;
    end

    // operand selection and sign of the pending product
    logic [31:0] op_a, op_b;
    logic        op_neg;
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        op_neg = 1'b0;
        case (step_reg)
            P_LCG:   begin op_a = noise_reg; op_b = ctns_pkg::LCG_MUL; end
            P_TONE1: begin op_a = mag(32'(sin_tone)); op_b = {16'd0, tenv_reg};
                           op_neg = sin_tone[15]; end
            P_TONE2: begin op_a = mag(tone_reg); op_b = {16'd0, ctns_pkg::TONE_LEVEL};
                           op_neg = tone_reg[31]; end
            P_SHAPE: begin op_a = mag(noise_val); op_b = mag(32'(sin_shape));
                           op_neg = noise_val[31] ^ sin_shape[15]; end
            P_NZ1:   begin op_a = mag(nz_reg); op_b = {16'd0, nenv_reg};
                           op_neg = nz_reg[31]; end
            P_NZ2:   begin op_a = mag(nz_reg); op_b = {16'd0, ctns_pkg::NOISE_LEVEL};
                           op_neg = nz_reg[31]; end
            P_GAIN:  begin op_a = mag(tone_reg + nz_reg); op_b = {16'd0, gain_sel};
                           op_neg = (tone_reg + nz_reg) < 0; end
            P_TENV:  begin op_a = {16'd0, tenv_reg}; op_b = {16'd0, regs.tone_decay_factor}; end
            P_NENV:  begin op_a = {16'd0, nenv_reg}; op_b = {16'd0, regs.noise_decay_factor}; end
            default: ;
        endcase
    end

    assign req.start = (state_reg == S_MUL);
    assign req.a     = op_a;
    assign req.b     = op_b;

    // shifted magnitude restored to signed
    logic [31:0] shmag;
    always_comb
    begin
        case (step_reg)
            P_TONE1, P_NZ1: shmag = prod[47:16];
            P_GAIN:         shmag = prod[45:14];
            default:        shmag = prod[46:15];
        endcase
        sres = neg_reg ? -$signed(shmag) : $signed(shmag);
    end

    logic acc_in;
    assign acc_in = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (acc_in) state_next = S_START;
            S_START: state_next = (active_reg && remain_reg != 16'd0) ? S_MUL : S_DONE;
            S_MUL:   state_next = S_WAIT;
            S_WAIT:  if (!rsp.busy) state_next = S_NEXT;
            S_NEXT:  state_next = (step_reg == P_NENV) ? S_DONE : S_MUL;
            S_DONE:  state_next = S_OUT;
            S_OUT:   state_next = S_HOLD;
            S_HOLD:  if (out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= P_LCG;
            active_reg <= 1'b0;
            remain_reg <= '0;
            accent_reg <= 1'b0;
            phase_reg  <= '0;
            noise_reg  <= ctns_pkg::NOISE_SEED;
            tenv_reg   <= ctns_pkg::ENV_FULL;
            nenv_reg   <= ctns_pkg::ENV_FULL;
            out_valid_reg <= 1'b0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (acc_in && in_ch.trigger)
                    begin
                        remain_reg <= regs.duration_samples;
                        active_reg <= regs.duration_samples != 16'd0;
                        accent_reg <= in_ch.accented;
                        phase_reg  <= '0;
                        noise_reg  <= ctns_pkg::NOISE_SEED;
                        tenv_reg   <= ctns_pkg::ENV_FULL;
                        nenv_reg   <= ctns_pkg::ENV_FULL;
                    end
                    step_reg <= P_LCG;
                end
                S_MUL: neg_reg <= op_neg;
                S_NEXT:
                begin
                    case (step_reg)
                        P_LCG:   noise_reg <= prod[31:0] + ctns_pkg::LCG_ADD;
                        P_TENV:  tenv_reg  <= prod[31:16];
                        P_NENV:  nenv_reg  <= prod[31:16];
                        default: ;
                    endcase
                    step_reg <= (step_reg == P_NENV) ? P_LCG : step_t'(step_reg + 4'd1);
                end
                S_DONE:
                begin
                    if (active_reg && remain_reg != 16'd0)
                    begin
                        phase_reg  <= phase_reg + step_sel;
                        remain_reg <= remain_reg - 16'd1;
                        active_reg <= remain_reg != 16'd1;
                    end
                    else
                        active_reg <= 1'b0;
                end
                S_OUT:  out_valid_reg <= 1'b1;
                S_HOLD: if (out_ch.ready) out_valid_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // product results and output register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_START)
        begin
            res_run_reg <= active_reg && remain_reg != 16'd0;
            sample_reg  <= '0;
        end
        if (state_reg == S_NEXT)
        begin
            case (step_reg)
                P_TONE1, P_TONE2: tone_reg <= sres;
                P_SHAPE, P_NZ1, P_NZ2: nz_reg <= sres;
                P_GAIN: sample_reg <= sres;
                default: ;
            endcase
        end
        if (state_reg == S_DONE)
        begin
            if (sample_reg > 32'sd32767)
                res_sample_reg <= 16'sh7FFF;
            else if (sample_reg < -32'sd32768)
                res_sample_reg <= -16'sd32768;
            else
                res_sample_reg <= sample_reg[15:0];
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.click_sample  = res_sample_reg;
    assign out_ch.click_running = res_run_reg;

    ap_vld: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_HOLD) else $error("result outside hold");
    ap_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_valid_reg) else $error("ready while result pending");
    ap_act: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && active_reg) |-> remain_reg != 16'd0)
        else $error("active with empty count");
endmodule
`default_nettype wire

/* sv/click_tone_noise_synth.sv */
// top level of the click synthesizer
// Channels: in_ch carries one sample tick per item (trigger, accented);
// out_ch returns exactly one item per tick (click_sample, click_running);
// cfg_ch writes the seven registers by index and is always ready. The user
// must write it only while no tick is in flight; the block itself does not
// enforce this. Each tick is worked by a sequencer that runs nine 32x32
// products through one bit-serial shift-add multiplier, each as start,
// wait and capture. A running tick passes S_START, the nine products,
// S_DONE and S_OUT before its result shows in S_HOLD; an idle tick skips
// the products. The next tick is taken once the result has been taken
// and the block is idle; for running ticks the multiplier sets the rate.
// The input is not ready again until the result item has been taken, so a
// stalled receiver simply holds the block with its result steady.
// Reset loads the register defaults, clears the click and seeds the noise.
`default_nettype none
module click_tone_noise_synth (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ctns_in_if.sink    in_ch,
    ctns_out_if.source out_ch,
    ctns_cfg_if.sink   cfg_ch
);
    ctns_pkg::cfg_t regs;

    ctns_regs u_regs (.clk(clk), .rst_n(rst_n), .cfg(cfg_ch), .regs(regs));
    ctns_core u_core (.clk(clk), .rst_n(rst_n), .regs(regs),
                      .in_ch(in_ch), .out_ch(out_ch));
endmodule
`default_nettype wire
